// File: sv/tccc_pkg.sv
// ----------------------------------------------------------------------------
// Text console cursor controller package
// Shared constants, codes and types of the cursor controller.
// ----------------------------------------------------------------------------
package tccc_pkg;

   localparam int CELL_W   = 36;
   localparam int CELL_H   = 32;
   localparam int SIZE_W   = 12;
   localparam int COLOR_W  = 24;
   localparam int CURSOR_W = 7;
   localparam int CHAR_W   = 8;
   localparam int ACTION_W = 2;
   localparam int CMD_W    = 2;
   localparam int ADDR_W   = 2;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 80;

   localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_WORD  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   localparam logic [CMD_W-1:0] CMD_GLYPH  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FILL   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SCROLL = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;

   localparam logic [ADDR_W-1:0] REG_WIDTH  = 2'd0;
   localparam logic [ADDR_W-1:0] REG_HEIGHT = 2'd1;
   localparam logic [ADDR_W-1:0] REG_TEXT   = 2'd2;
   localparam logic [ADDR_W-1:0] REG_BACK   = 2'd3;

   localparam logic [SIZE_W-1:0]  RESET_WIDTH  = 12'd640;
   localparam logic [SIZE_W-1:0]  RESET_HEIGHT = 12'd480;
   localparam logic [COLOR_W-1:0] RESET_TEXT   = 24'hFFFFFF;
   localparam logic [COLOR_W-1:0] RESET_BACK   = 24'h000000;
   localparam logic [CURSOR_W-1:0] RESET_COLS  = CURSOR_W'(640 / CELL_W);

   localparam logic [SIZE_W-1:0] CELL_W_PIX = SIZE_W'(CELL_W);
   localparam logic [SIZE_W-1:0] CELL_H_PIX = SIZE_W'(CELL_H);

   // Width / 36 is (width / 4) / 9, and x / 9 equals (x * 1821) >> 14 for x below 1024.
   localparam logic [10:0] COLS_RECIP = 11'd1821;
   localparam int          COLS_SHIFT = 14;

   localparam logic [1:0] JOB_NONE  = 2'd0;
   localparam logic [1:0] JOB_GLYPH = 2'd1;
   localparam logic [1:0] JOB_ERASE = 2'd2;
   localparam logic [1:0] JOB_CLEAR = 2'd3;

   typedef struct packed {
      logic [1:0]          kind;
      logic                scroll;
      logic [CHAR_W-1:0]   glyph;
      logic [CURSOR_W-1:0] col;
      logic [CURSOR_W-1:0] row;
   } job_type;

   typedef struct packed {
      logic [SIZE_W-1:0]  width;
      logic [SIZE_W-1:0]  height;
      logic [COLOR_W-1:0] text_color;
      logic [COLOR_W-1:0] background_color;
   } cfg_type;

   function automatic logic [CURSOR_W-1:0] cols_of(input logic [SIZE_W-1:0] width);
      logic [20:0] prod;
      prod = width[SIZE_W-1:2] * COLS_RECIP;
      return prod[COLS_SHIFT +: CURSOR_W];
   endfunction

endpackage

// File: sv/text_console_cursor_controller_unit.sv
// ----------------------------------------------------------------------------
// Text console cursor controller
// Tracks a text cursor over 36x32-pixel cells and emits draw commands.
//
// Items come in on the req_ channel: the action in req_tuser, the character
// and the word length in req_tdata. Each item gives zero to three commands on
// the rsp_ channel, one transfer each, with rsp_tlast on the final one.
// The csr_ port writes the screen size and the two colors; a size write also homes the
// cursor. The user must make writes while no item is in flight; the block does not enforce it.
//
// The front end updates the cursor in the cycle an item is accepted and
// queues a job; the job passes through the queue and the output register
// before the first command appears. The command generator issues one
// command per cycle while the receiver does not stall. Items that give no
// command queue no job. The job queue lets items be taken while earlier
// commands still drain.
// Reset restores 640x480, white text on black and homes the cursor, with
// the queue and the output register empty. When the receiver stalls, the
// output register holds, the queue fills and req_tready then drops.
// ----------------------------------------------------------------------------
module text_console_cursor_controller_unit
   import tccc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // char_code, word_length
   input  logic [ACTION_W-1:0]   req_tuser,   // action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // glyph, pos_x, pos_y, rect_width,
                                              // rect_height, color
   output logic [CMD_W-1:0]      rsp_tuser,   // command
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [ADDR_W-1:0]     csr_addr,
   input  logic [COLOR_W-1:0]    csr_wdata
);

   logic    push;
   job_type push_job;
   logic    queue_full;
   logic    pop;
   logic    head_valid;
   job_type head_job;
   cfg_type cfg;

   tccc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job),
      .cfg        (cfg)
   );

   tccc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   tccc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (head_valid),
      .job        (head_job),
      .cfg        (cfg),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: sv/tccc_front.sv
// ----------------------------------------------------------------------------
// Cursor controller front end
// Holds the configuration and the cursor, accepts items and turns each one
// that gives a command into a job for the command generator.
// ----------------------------------------------------------------------------
module tccc_front
   import tccc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [ACTION_W-1:0]   req_tuser,
   input  logic                  csr_we,
   input  logic [ADDR_W-1:0]     csr_addr,
   input  logic [COLOR_W-1:0]    csr_wdata,
   input  logic                  queue_full,
   output logic                  push,
   output job_type               push_job,
   output cfg_type               cfg
);

   logic [SIZE_W-1:0]   width_ff, width_in;
   logic [SIZE_W-1:0]   height_ff, height_in;
   logic [COLOR_W-1:0]  text_ff, text_in;
   logic [COLOR_W-1:0]  back_ff, back_in;
   logic [CURSOR_W-1:0] cols_ff, cols_in;
   logic [CURSOR_W-1:0] col_ff, col_in;
   logic [CURSOR_W-1:0] row_ff, row_in;

   logic                accept;
   logic [CHAR_W-1:0]   char_code;
   logic [CHAR_W-1:0]   word_length;
   logic [CURSOR_W-1:0] rows;
   logic [CURSOR_W-1:0] col_next;
   logic [CURSOR_W-1:0] row_next;
   logic [CURSOR_W-1:0] col_inc;
   logic [CURSOR_W-1:0] row_inc;
   logic [CHAR_W:0]     word_end;
   logic                new_line;
   job_type             job;

   assign accept      = req_tvalid && !queue_full;
   assign req_tready  = !queue_full;
   assign char_code   = req_tdata[CHAR_W-1:0];
   assign word_length = req_tdata[2*CHAR_W-1:CHAR_W];
   assign rows        = height_ff[SIZE_W-1:SIZE_W-CURSOR_W];
   assign col_inc     = col_ff + CURSOR_W'(1);
   assign row_inc     = row_ff + CURSOR_W'(1);
   assign word_end    = {2'b00, col_ff} + {1'b0, word_length};

   always_comb begin
      job      = '0;
      job.kind = JOB_NONE;
      job.col  = col_ff;
      job.row  = row_ff;
      col_next = col_ff;
      row_next = row_ff;
      new_line = 1'b0;
      case (req_tuser)
         ACT_PUT: begin
            if (char_code == CHAR_NEWLINE) begin
               new_line = 1'b1;
            end else if (char_code == CHAR_BACKSPACE) begin
               if (col_ff != '0) begin
                  col_next = col_ff - CURSOR_W'(1);
                  job.kind = JOB_ERASE;
                  job.col  = col_ff - CURSOR_W'(1);
               end
            end else begin
               job.kind  = JOB_GLYPH;
               job.glyph = char_code;
               col_next  = col_inc;
               new_line  = (col_inc >= cols_ff);
            end
         end
         ACT_WORD: begin
            new_line = (col_ff != '0) && (word_end > {2'b00, cols_ff});
         end
         ACT_CLEAR: begin
            job.kind = JOB_CLEAR;
            col_next = '0;
            row_next = '0;
         end
         default: begin
         end
      endcase
      if (new_line) begin
         col_next = '0;
         if (row_inc >= rows) begin
            job.scroll = 1'b1;
            row_next   = (rows != '0) ? rows - CURSOR_W'(1) : '0;
         end else begin
            row_next = row_inc;
         end
      end
   end

   assign push     = accept && ((job.kind != JOB_NONE) || job.scroll);
   assign push_job = job;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      text_in   = text_ff;
      back_in   = back_ff;
      cols_in   = cols_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_WIDTH: begin
               width_in = csr_wdata[SIZE_W-1:0];
               cols_in  = cols_of(csr_wdata[SIZE_W-1:0]);
               col_in   = '0;
               row_in   = '0;
            end
            REG_HEIGHT: begin
               height_in = csr_wdata[SIZE_W-1:0];
               col_in    = '0;
               row_in    = '0;
            end
            REG_TEXT: begin
               text_in = csr_wdata;
            end
            REG_BACK: begin
               back_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         col_in = col_next;
         row_in = row_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         text_ff   <= RESET_TEXT;
         back_ff   <= RESET_BACK;
         cols_ff   <= RESET_COLS;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         text_ff   <= text_in;
         back_ff   <= back_in;
         cols_ff   <= cols_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   assign cfg.width            = width_ff;
   assign cfg.height           = height_ff;
   assign cfg.text_color       = text_ff;
   assign cfg.background_color = back_ff;

endmodule

// File: sv/tccc_queue.sv
// ----------------------------------------------------------------------------
// Cursor controller job queue
// Short first-in first-out queue of jobs between the front end and the
// command generator.
// ----------------------------------------------------------------------------
module tccc_queue
   import tccc_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   job_type              entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full       = (count_ff == COUNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: sv/tccc_back.sv
// ----------------------------------------------------------------------------
// Cursor controller command generator
// Expands each job into one to three draw commands and drives the result
// channel through an output register.
// ----------------------------------------------------------------------------
module tccc_back
   import tccc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   input  job_type               job,
   input  cfg_type               cfg,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [CMD_W-1:0]      rsp_tuser,
   output logic                  rsp_tlast
);

   logic [1:0]            step_ff, step_in;
   logic                  valid_ff, valid_in;
   logic [RSP_DATA_W-1:0] data_ff;
   logic [CMD_W-1:0]      cmd_ff;
   logic                  last_ff;

   logic                  load;
   logic                  has_first;
   logic [1:0]            count;
   logic [1:0]            phase;
   logic                  last;
   logic [SIZE_W-1:0]     cell_x;
   logic [SIZE_W-1:0]     cell_y;
   logic [SIZE_W-1:0]     bottom_y;
   logic [CMD_W-1:0]      cmd;
   logic [CHAR_W-1:0]     glyph;
   logic [SIZE_W-1:0]     pos_x;
   logic [SIZE_W-1:0]     pos_y;
   logic [SIZE_W-1:0]     rect_w;
   logic [SIZE_W-1:0]     rect_h;
   logic [COLOR_W-1:0]    color;

   assign has_first = (job.kind != JOB_NONE);
   assign count     = {job.scroll, 1'b0} + {1'b0, has_first};
   assign phase     = step_ff - {1'b0, has_first};
   assign last      = (step_ff == count - 2'd1);
   assign load      = job_valid && (!valid_ff || rsp_tready);
   assign pop       = load && last;

   assign cell_x   = {job.col, 5'b00000} + {3'b000, job.col, 2'b00};
   assign cell_y   = {job.row, 5'b00000};
   assign bottom_y = (cfg.height >= CELL_H_PIX) ? cfg.height - CELL_H_PIX : '0;

   always_comb begin
      cmd    = CMD_FILL;
      glyph  = '0;
      pos_x  = '0;
      pos_y  = '0;
      rect_w = '0;
      rect_h = '0;
      color  = '0;
      if (has_first && (step_ff == 2'd0)) begin
         case (job.kind)
            JOB_GLYPH: begin
               cmd   = CMD_GLYPH;
               glyph = job.glyph;
               pos_x = cell_x;
               pos_y = cell_y;
               color = cfg.text_color;
            end
            JOB_ERASE: begin
               pos_x  = cell_x;
               pos_y  = cell_y;
               rect_w = CELL_W_PIX;
               rect_h = CELL_H_PIX;
               color  = cfg.background_color;
            end
            default: begin
               rect_w = cfg.width;
               rect_h = cfg.height;
               color  = cfg.background_color;
            end
         endcase
      end else if (phase == 2'd0) begin
         cmd    = CMD_SCROLL;
         rect_w = cfg.width;
         rect_h = CELL_H_PIX;
      end else begin
         pos_y  = bottom_y;
         rect_w = cfg.width;
         rect_h = CELL_H_PIX;
         color  = cfg.background_color;
      end
   end

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      if (load) begin
         step_in  = last ? 2'd0 : step_ff + 2'd1;
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= {color, rect_h, rect_w, pos_y, pos_x, glyph};
         cmd_ff  <= cmd;
         last_ff <= last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = cmd_ff;
   assign rsp_tlast  = last_ff;

endmodule

// File: sv/tccc_checker.sv
// ----------------------------------------------------------------------------
// Cursor controller checker
// Watches the result channel of the cursor controller.
// ----------------------------------------------------------------------------
module tccc_checker
   import tccc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [CMD_W-1:0]      rsp_tuser,
   input logic                  rsp_tlast
);

   // A stalled transfer keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A glyph draw carries no rectangle size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == CMD_GLYPH) |-> (rsp_tdata[55:32] == '0))
      else $error("glyph draw with nonzero size");

   // A scroll is never the last command of an item; it is one cell high and carries no glyph.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == CMD_SCROLL) |-> !rsp_tlast
         && (rsp_tdata[55:44] == CELL_H_PIX) && (rsp_tdata[7:0] == '0))
      else $error("malformed scroll command");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == CMD_GLYPH) || (rsp_tuser == CMD_FILL)
         || (rsp_tuser == CMD_SCROLL))
      else $error("unknown command code");

endmodule

bind text_console_cursor_controller_unit tccc_checker u_checker (.*);
